// File: rtl/fifp_pkg.sv
// ----------------------------------------------------------------------------
// fifp_pkg
// Shared types, constants and microcode for the fern point generator.
// ----------------------------------------------------------------------------
package fifp_pkg;

   localparam int COORD_W    = 24;
   localparam int COEF_W     = 17;
   localparam int COEF_FRAC  = 16;
   localparam int SCALE_FRAC = 12;
   localparam int MUL_W      = 25;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 44;
   localparam int SUM_W      = ACC_W - COEF_FRAC + 1;
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int DIM_REG_W  = 13;
   localparam int K_W        = 2;
   localparam int SHADE_W    = 6;
   localparam int STEP_W     = 4;

   typedef logic [STEP_W-1:0] step_type;
   localparam step_type LAST_STEP = step_type'(10);

   // affine coefficients, 16 fractional bits
   localparam logic signed [COEF_W-1:0] COEF_A [4] = '{17'sd0, 17'sd12911, -17'sd12648, 17'sd55640};
   localparam logic signed [COEF_W-1:0] COEF_B [4] = '{17'sd0, -17'sd14811, 17'sd18547, 17'sd2425};
   localparam logic signed [COEF_W-1:0] COEF_C [4] = '{17'sd0, 17'sd14811, 17'sd15073, -17'sd2425};
   localparam logic signed [COEF_W-1:0] COEF_D [4] = '{17'sd10486, 17'sd12911, 17'sd15598, 17'sd55640};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN,
      CSR_Y_TOP,
      CSR_X_SCALE,
      CSR_Y_SCALE,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_origin;
      logic signed [COORD_W-1:0] y_top;
      logic [CSR_W-1:0]          x_scale;
      logic [CSR_W-1:0]          y_scale;
      logic [DIM_REG_W-1:0]      image_width;
      logic [DIM_REG_W-1:0]      image_height;
   } csr_regs_type;

   typedef enum logic [2:0] {MUL_AX, MUL_BY, MUL_CX, MUL_DY, MUL_SX, MUL_SY} mul_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {DIFF_HOLD, DIFF_X, DIFF_Y} diff_op_type;
   typedef enum logic [1:0] {JC_NEXT, JC_REQ, JC_OUT} jump_cond_type;

   typedef struct packed {
      logic          accept;
      mul_sel_type   mul_sel;
      acc_op_type    acc_op;
      logic          wr_px;
      logic          wr_py;
      diff_op_type   diff_op;
      logic          wr_col;
      logic          wr_row;
      logic          deliver;
      jump_cond_type jump_cond;
      step_type      jump_to;
   } ctrl_word_type;

   // one control word per step; a single multiplier is shared throughout
   function automatic ctrl_word_type ucode_rom(input step_type s);
      ctrl_word_type w;
      w = '0;
      w.mul_sel   = MUL_AX;
      w.acc_op    = ACC_HOLD;
      w.diff_op   = DIFF_HOLD;
      w.jump_cond = JC_NEXT;
      case (s)
         4'd0: begin
            w.accept    = 1'b1;
            w.jump_cond = JC_REQ;
         end
         4'd1: w.mul_sel = MUL_AX;
         4'd2: begin
            w.acc_op  = ACC_LOAD;
            w.mul_sel = MUL_BY;
         end
         4'd3: begin
            w.acc_op  = ACC_ADD;
            w.mul_sel = MUL_CX;
         end
         4'd4: begin
            w.wr_px   = 1'b1;
            w.acc_op  = ACC_LOAD;
            w.mul_sel = MUL_DY;
         end
         4'd5: begin
            w.acc_op  = ACC_ADD;
            w.diff_op = DIFF_X;
         end
         4'd6: begin
            w.wr_py   = 1'b1;
            w.mul_sel = MUL_SX;
         end
         4'd7: begin
            w.diff_op = DIFF_Y;
            w.wr_col  = 1'b1;
         end
         4'd8: w.mul_sel = MUL_SY;
         4'd9: w.wr_row = 1'b1;
         4'd10: begin
            w.deliver   = 1'b1;
            w.jump_cond = JC_OUT;
            w.jump_to   = '0;
         end
         default: begin
            w.jump_cond = JC_OUT;
            w.jump_to   = '0;
         end
      endcase
      return w;
   endfunction

   function automatic logic [SHADE_W-1:0] shade_of(input logic [K_W-1:0] k);
      logic [SHADE_W-1:0] v;
      case (k)
         2'd0:    v = 6'd0;
         2'd1:    v = 6'd20;
         2'd2:    v = 6'd40;
         default: v = 6'd60;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/fifp_sequencer.sv
// ----------------------------------------------------------------------------
// fifp_sequencer
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module fifp_sequencer
   import fifp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   output ctrl_word_type ctrl
);

   step_type step_ff;
   step_type step_in;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      step_in = step_ff + step_type'(1);
      case (ctrl.jump_cond)
         JC_REQ: begin
            if (!req_valid) step_in = step_ff;
         end
         JC_OUT: begin
            step_in = out_free ? ctrl.jump_to : step_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= LAST_STEP) else $error("step counter past end of program");
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && req_valid |=> !ctrl.accept) else $error("sequencer stayed idle after accept");
   a_return_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.deliver && out_free |=> ctrl.accept) else $error("sequencer did not return to idle");
`endif

endmodule

// File: rtl/fifp_datapath.sv
// ----------------------------------------------------------------------------
// fifp_datapath
// Shared multiplier, accumulator, point registers and pixel mapping.
// ----------------------------------------------------------------------------
module fifp_datapath
   import fifp_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16,
   parameter int RANDOM_BITS     = 16,
   parameter int DIM_BITS        = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_word_type          ctrl,
   input  logic                   req_valid,
   input  logic [RANDOM_BITS-1:0] random_fraction,
   input  csr_regs_type           csr,
   output logic [DIM_BITS-1:0]    pixel_column,
   output logic [DIM_BITS-1:0]    pixel_row,
   output logic [K_W-1:0]         index,
   output logic                   in_range
);

   localparam longint unsigned TH_LO_L  = ((64'd1 << RANDOM_BITS) + 64'd50) / 64'd100;
   localparam longint unsigned TH_MID_L = ((64'd8 << RANDOM_BITS) + 64'd50) / 64'd100;
   localparam longint unsigned TH_HI_L  = ((64'd15 << RANDOM_BITS) + 64'd50) / 64'd100;
   localparam logic [RANDOM_BITS-1:0] TH_LO  = RANDOM_BITS'(TH_LO_L);
   localparam logic [RANDOM_BITS-1:0] TH_MID = RANDOM_BITS'(TH_MID_L);
   localparam logic [RANDOM_BITS-1:0] TH_HI  = RANDOM_BITS'(TH_HI_L);

   localparam longint OFF_160_L = ((longint'(160) << COORD_FRAC_BITS) + 500) / 1000;
   localparam longint OFF_44_L  = ((longint'(44) << COORD_FRAC_BITS) + 500) / 1000;
   localparam logic signed [COORD_W-1:0] OFF_160 = COORD_W'(OFF_160_L);
   localparam logic signed [COORD_W-1:0] OFF_44  = COORD_W'(OFF_44_L);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(longint'(1) << (COEF_FRAC - 1));
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((longint'(1) << (COORD_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(longint'(1) << (COORD_W - 1)));

   localparam int PIX_SHIFT = SCALE_FRAC + COORD_FRAC_BITS;
   localparam int PIX_W     = PROD_W - PIX_SHIFT;
   localparam int PX_W      = (PIX_W > DIM_BITS + 1) ? PIX_W : DIM_BITS + 2;
   localparam logic signed [PX_W-1:0] PX_MAX = PX_W'((longint'(1) << DIM_BITS) - 1);

   logic [K_W-1:0]              k_ff;
   logic [K_W-1:0]              k_in;
   logic signed [COORD_W-1:0]   point_x_ff;
   logic signed [COORD_W-1:0]   point_y_ff;
   logic signed [MUL_W-1:0]     op_a;
   logic signed [MUL_W-1:0]     op_b;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [MUL_W-1:0]     diff_ff;
   logic signed [COORD_W-1:0]   off;
   logic signed [COORD_W-1:0]   off_f;
   logic signed [SUM_W-1:0]     sum;
   logic signed [COORD_W-1:0]   sat;
   logic signed [PX_W-1:0]      pix;
   logic signed [PX_W-1:0]      pix_limit;
   logic [DIM_BITS-1:0]         pix_clamp;
   logic                        pix_ok;
   logic [DIM_BITS-1:0]         col_ff;
   logic [DIM_BITS-1:0]         row_ff;
   logic                        col_ok_ff;
   logic                        row_ok_ff;

   // transform pick: a tie with a threshold does not pass it
   assign k_in = {1'b0, random_fraction > TH_LO} + {1'b0, random_fraction > TH_MID}
               + {1'b0, random_fraction > TH_HI};

   always_comb begin
      case (ctrl.mul_sel)
         MUL_AX: begin
            op_a = MUL_W'(COEF_A[k_ff]);
            op_b = MUL_W'(point_x_ff);
         end
         MUL_BY: begin
            op_a = MUL_W'(COEF_B[k_ff]);
            op_b = MUL_W'(point_y_ff);
         end
         MUL_CX: begin
            op_a = MUL_W'(COEF_C[k_ff]);
            op_b = MUL_W'(point_x_ff);
         end
         MUL_DY: begin
            op_a = MUL_W'(COEF_D[k_ff]);
            op_b = MUL_W'(point_y_ff);
         end
         MUL_SX: begin
            op_a = $signed({1'b0, csr.x_scale});
            op_b = diff_ff;
         end
         MUL_SY: begin
            op_a = $signed({1'b0, csr.y_scale});
            op_b = diff_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      case (k_ff)
         2'd1:    off_f = OFF_160;
         2'd2:    off_f = OFF_44;
         2'd3:    off_f = OFF_160;
         default: off_f = '0;
      endcase
      off = ctrl.wr_py ? off_f : '0;
      // acc already holds the rounding half, so the shift rounds to nearest
      sum = SUM_W'(acc_ff >>> COEF_FRAC) + SUM_W'(off);
      if (sum > SAT_MAX) begin
         sat = COORD_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         sat = COORD_W'(SAT_MIN);
      end else begin
         sat = COORD_W'(sum);
      end
   end

   // pixel = floor(scale * diff / 2^(12+frac)), clamped, range checked unclamped
   always_comb begin
      pix       = PX_W'(prod_ff >>> PIX_SHIFT);
      pix_limit = ctrl.wr_row ? $signed(PX_W'(csr.image_height))
                              : $signed(PX_W'(csr.image_width));
      pix_ok    = !pix[PX_W-1] && (pix < pix_limit);
      if (pix[PX_W-1]) begin
         pix_clamp = '0;
      end else if (pix > PX_MAX) begin
         pix_clamp = '1;
      end else begin
         pix_clamp = DIM_BITS'(pix);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
      end else begin
         if (ctrl.wr_px) point_x_ff <= sat;
         if (ctrl.wr_py) point_y_ff <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept && req_valid) k_ff <= k_in;
      prod_ff <= op_a * op_b;
      case (ctrl.acc_op)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff) + HALF;
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         default:  ;
      endcase
      case (ctrl.diff_op)
         DIFF_X:  diff_ff <= $signed({point_x_ff[COORD_W-1], point_x_ff})
                           - $signed({csr.x_origin[COORD_W-1], csr.x_origin});
         DIFF_Y:  diff_ff <= $signed({csr.y_top[COORD_W-1], csr.y_top})
                           - $signed({point_y_ff[COORD_W-1], point_y_ff});
         default: ;
      endcase
      if (ctrl.wr_col) begin
         col_ff    <= pix_clamp;
         col_ok_ff <= pix_ok;
      end
      if (ctrl.wr_row) begin
         row_ff    <= pix_clamp;
         row_ok_ff <= pix_ok;
      end
   end

   assign pixel_column = col_ff;
   assign pixel_row    = row_ff;
   assign index        = k_ff;
   assign in_range     = col_ok_ff & row_ok_ff;

endmodule

// File: rtl/fern_ifs_point_generator.sv
// ----------------------------------------------------------------------------
// fern_ifs_point_generator
// Chaos-game step of a four-map fern IFS, mapped to a pixel position.
// ----------------------------------------------------------------------------
// Requests are taken one at a time: a new request is accepted only after the
// previous one has passed its deliver step; the microcode program runs the
// six products of a step in series through one shared 25x25 multiplier.
// A finished response waits in the output register while the next request runs.
// Reset: synchronous; point returns to the origin, CSRs to their defaults.
// ----------------------------------------------------------------------------
module fern_ifs_point_generator
   import fifp_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16,
   parameter int RANDOM_BITS     = 16,
   parameter int DIM_BITS        = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [RANDOM_BITS-1:0] req_random_fraction,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DIM_BITS-1:0]    rsp_pixel_column,
   output logic [DIM_BITS-1:0]    rsp_pixel_row,
   output logic [SHADE_W-1:0]     rsp_shade,
   output logic                   rsp_in_range,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   csr_regs_type        csr_ff;
   ctrl_word_type       ctrl;
   logic                out_free;
   logic [DIM_BITS-1:0] dp_column;
   logic [DIM_BITS-1:0] dp_row;
   logic [K_W-1:0]      dp_index;
   logic                dp_in_range;
   logic                rsp_valid_ff;
   logic [DIM_BITS-1:0] rsp_column_ff;
   logic [DIM_BITS-1:0] rsp_row_ff;
   logic [SHADE_W-1:0]  rsp_shade_ff;
   logic                rsp_in_range_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.x_origin     <= COORD_W'(-262144);
         csr_ff.y_top        <= COORD_W'(65536);
         csr_ff.x_scale      <= CSR_W'(524288);
         csr_ff.y_scale      <= CSR_W'(524288);
         csr_ff.image_width  <= DIM_REG_W'(256);
         csr_ff.image_height <= DIM_REG_W'(256);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_X_ORIGIN:     csr_ff.x_origin     <= csr_wdata;
            CSR_Y_TOP:        csr_ff.y_top        <= csr_wdata;
            CSR_X_SCALE:      csr_ff.x_scale      <= csr_wdata;
            CSR_Y_SCALE:      csr_ff.y_scale      <= csr_wdata;
            CSR_IMAGE_WIDTH:  csr_ff.image_width  <= csr_wdata[DIM_REG_W-1:0];
            CSR_IMAGE_HEIGHT: csr_ff.image_height <= csr_wdata[DIM_REG_W-1:0];
            default:          ;
         endcase
      end
   end

   fifp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   fifp_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .RANDOM_BITS     (RANDOM_BITS),
      .DIM_BITS        (DIM_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_valid       (req_valid),
      .random_fraction (req_random_fraction),
      .csr             (csr_ff),
      .pixel_column    (dp_column),
      .pixel_row       (dp_row),
      .index           (dp_index),
      .in_range        (dp_in_range)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.deliver && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.deliver && out_free) begin
         rsp_column_ff   <= dp_column;
         rsp_row_ff      <= dp_row;
         rsp_shade_ff    <= shade_of(dp_index);
         rsp_in_range_ff <= dp_in_range;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_column = rsp_column_ff;
   assign rsp_pixel_row    = rsp_row_ff;
   assign rsp_shade        = rsp_shade_ff;
   assign rsp_in_range     = rsp_in_range_ff;

`ifndef SYNTHESIS
   a_rsp_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.deliver)) else $error("response without deliver step");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fern point generator. Random fractions go in
// over valid/ready; a local chaos-game predictor tracks the plane point and
// the window registers and checks every pixel transaction field by field.
// Window settings are changed between batches, extremes included.
// ----------------------------------------------------------------------------
module tb_top
   import fifp_pkg::*;
();

   localparam int RANDOM_W   = 16;
   localparam int DIM_W      = 12;
   localparam int COORD_FRAC = 16;
   localparam int MUL_FRAC   = 16;
   localparam int PIX_SHIFT  = 12 + COORD_FRAC;

   localparam longint COORD_MAX = 64'sd8388607;
   localparam longint COORD_MIN = -64'sd8388608;
   localparam longint PIX_MAX   = 64'sd4095;

   // cumulative probabilities 0.01, 0.08, 0.15 in Q0.16
   localparam int THR_STEM   = (1 * 65536 + 50) / 100;
   localparam int THR_LEAF_1 = (8 * 65536 + 50) / 100;
   localparam int THR_LEAF_2 = (15 * 65536 + 50) / 100;

   // y offsets 0.160 and 0.044 in plane format
   localparam longint OFS_160 = (160 * 65536 + 500) / 1000;
   localparam longint OFS_44  = (44 * 65536 + 500) / 1000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   // window that frames the whole fern: x from -2.75, y down from 10.5
   localparam logic [CSR_W-1:0] FERN_X0    = 24'hFD4000;
   localparam logic [CSR_W-1:0] FERN_Y0    = 24'h0A8000;
   localparam logic [CSR_W-1:0] FERN_SCALE = 24'd98304;

   localparam int NUM_PHASES  = 14;
   localparam int PHASE_ITEMS = 110;
   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {MAP_STEM, MAP_LEAF_1, MAP_LEAF_2, MAP_BODY} fern_map_type;

   typedef struct packed {
      logic [DIM_W-1:0]   column;
      logic [DIM_W-1:0]   row;
      logic [SHADE_W-1:0] shade;
      logic               in_range;
   } fern_pixel_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [RANDOM_W-1:0]  req_random_fraction = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DIM_W-1:0]     rsp_pixel_column;
   logic [DIM_W-1:0]     rsp_pixel_row;
   logic [SHADE_W-1:0]   rsp_shade;
   logic                 rsp_in_range;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   logic [RANDOM_W-1:0] fraction_queue [$];
   fern_pixel_type      expected_pixels [$];
   int                  mismatch_count = 0;
   int                  idle_odds = 0;
   bit                  long_hold_request = 1'b0;
   bit                  req_taken = 1'b0;
   int                  send_gap = 0;
   int                  hold_left = 0;
   int                  quiet_cycles = 0;

   // predictor state: plane point and window registers, reset values
   longint fern_x = 0;
   longint fern_y = 0;
   longint win_x_origin = -262144;
   longint win_y_top    = 65536;
   longint win_x_scale  = 524288;
   longint win_y_scale  = 524288;
   longint win_width    = 256;
   longint win_height   = 256;

   fern_ifs_point_generator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_column    (rsp_pixel_column),
      .rsp_pixel_row       (rsp_pixel_row),
      .rsp_shade           (rsp_shade),
      .rsp_in_range        (rsp_in_range),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // round half up, then saturate to the 24-bit plane range
   function automatic longint fern_affine(input longint p, input longint q,
                                          input longint x, input longint y,
                                          input longint offset);
      longint acc;
      acc = ((p * x + q * y + longint'(32768)) >>> MUL_FRAC) + offset;
      if (acc > COORD_MAX) return COORD_MAX;
      if (acc < COORD_MIN) return COORD_MIN;
      return acc;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_pixel(input longint v);
      if (v < 0) return '0;
      if (v > PIX_MAX) return DIM_W'(PIX_MAX);
      return v[DIM_W-1:0];
   endfunction

   function automatic fern_pixel_type advance_fern(input logic [RANDOM_W-1:0] fraction);
      fern_map_type   map;
      longint         a, b, c, d, f, next_x, next_y, col, row;
      fern_pixel_type px;
      // a fraction equal to a threshold stays below it
      if (fraction > THR_LEAF_2)      map = MAP_BODY;
      else if (fraction > THR_LEAF_1) map = MAP_LEAF_2;
      else if (fraction > THR_STEM)   map = MAP_LEAF_1;
      else                            map = MAP_STEM;
      case (map)
         MAP_STEM: begin
            a = 0;      b = 0;      c = 0;      d = 10486; f = 0;
         end
         MAP_LEAF_1: begin
            a = 12911;  b = -14811; c = 14811;  d = 12911; f = OFS_160;
         end
         MAP_LEAF_2: begin
            a = -12648; b = 18547;  c = 15073;  d = 15598; f = OFS_44;
         end
         default: begin
            a = 55640;  b = 2425;   c = -2425;  d = 55640; f = OFS_160;
         end
      endcase
      next_x = fern_affine(a, b, fern_x, fern_y, 0);
      next_y = fern_affine(c, d, fern_x, fern_y, f);
      fern_x = next_x;
      fern_y = next_y;
      col = (win_x_scale * (next_x - win_x_origin)) >>> PIX_SHIFT;
      row = (win_y_scale * (win_y_top - next_y)) >>> PIX_SHIFT;
      px.column   = clamp_pixel(col);
      px.row      = clamp_pixel(row);
      px.shade    = SHADE_W'(20 * int'(map));
      px.in_range = col >= 0 && col < win_width && row >= 0 && row < win_height;
      return px;
   endfunction

   function automatic logic [RANDOM_W-1:0] boundary_fraction(input int i);
      case (i)
         0:       return '0;
         1:       return RANDOM_W'(THR_STEM);
         2:       return RANDOM_W'(THR_STEM + 1);
         3:       return RANDOM_W'(THR_LEAF_1);
         4:       return RANDOM_W'(THR_LEAF_1 + 1);
         5:       return RANDOM_W'(THR_LEAF_2);
         6:       return RANDOM_W'(THR_LEAF_2 + 1);
         default: return '1;
      endcase
   endfunction

   function automatic logic [RANDOM_W-1:0] draw_fraction();
      case ($urandom_range(0, 9))
         0:       return boundary_fraction($urandom_range(0, 7));
         1, 2:    return RANDOM_W'($urandom_range(0, THR_LEAF_2 + 1));
         default: return RANDOM_W'($urandom());
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [DIM_W-1:0] want,
                                       input logic [DIM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      logic signed [CSR_W-1:0] signed_value;
      signed_value = value;
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_X_ORIGIN:     win_x_origin = longint'(signed_value);
         CSR_Y_TOP:        win_y_top    = longint'(signed_value);
         CSR_X_SCALE:      win_x_scale  = longint'(value);
         CSR_Y_SCALE:      win_y_scale  = longint'(value);
         CSR_IMAGE_WIDTH:  win_width    = longint'(value[DIM_REG_W-1:0]);
         CSR_IMAGE_HEIGHT: win_height   = longint'(value[DIM_REG_W-1:0]);
         default: ;
      endcase
   endtask

   // all six registers, then a write to an unmapped index that must be dropped
   task automatic program_window(input logic [CSR_W-1:0] x0, input logic [CSR_W-1:0] y0,
                                 input logic [CSR_W-1:0] xs, input logic [CSR_W-1:0] ys,
                                 input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h);
      write_reg(CSR_X_ORIGIN, x0);
      write_reg(CSR_Y_TOP, y0);
      write_reg(CSR_X_SCALE, xs);
      write_reg(CSR_Y_SCALE, ys);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg($urandom_range(0, 1) ? CSR_UNUSED_HI : CSR_UNUSED_LO, CSR_W'($urandom()));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (fraction_queue.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (fraction_queue.size() != 0) begin
            req_valid           <= 1'b1;
            req_random_fraction <= fraction_queue.pop_front();
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               send_gap = $urandom_range(1, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver, with short stall bursts and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         hold_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check pixel transactions, predict on each accepted fraction
   always @(posedge clock) begin : monitor
      fern_pixel_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual col %0d row %0d",
                        $time, rsp_pixel_column, rsp_pixel_row);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_column", want.column, rsp_pixel_column);
               check_field("pixel_row", want.row, rsp_pixel_row);
               check_field("shade", DIM_W'(want.shade), DIM_W'(rsp_shade));
               check_field("in_range", DIM_W'(want.in_range), DIM_W'(rsp_in_range));
            end
         end
         if (req_valid && req_ready) begin
            expected_pixels.push_back(advance_fern(req_random_fraction));
            req_taken = 1'b1;
         end
      end
   end

   // watchdog: outstanding work but no transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (fraction_queue.size() == 0 && !req_valid && expected_pixels.size() == 0)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: threshold ties and field extremes, reset window first
      idle_odds = 5;
      for (int i = 0; i < 8; i++) fraction_queue.push_back(boundary_fraction(i));
      fraction_queue.push_back(16'h8000);
      fraction_queue.push_back(16'h0001);
      wait_idle();
      program_window(FERN_X0, FERN_Y0, FERN_SCALE, FERN_SCALE, 24'd132, 24'd256);
      for (int i = 7; i >= 0; i--) fraction_queue.push_back(boundary_fraction(i));
      repeat (4) fraction_queue.push_back(draw_fraction());

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            // zero scale: everything lands on pixel 0
            0: program_window(FERN_X0, FERN_Y0, 24'd0, 24'd0, 24'd256, 24'd256);
            // empty image: nothing in range
            1: program_window(FERN_X0, FERN_Y0, FERN_SCALE, FERN_SCALE, 24'd0, 24'd0);
            // width/height upper bits are dropped, giving 8191
            2: program_window(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF,
                              24'hFFFFFF, 24'hFFFFFF);
            3: program_window(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
                              24'd4096, 24'd4096);
            // pixels past 4095 but still inside an 8191 image: clamped, in range
            4: program_window(FERN_X0, FERN_Y0, 24'd4194304, 24'd2457600,
                              24'h001FFF, 24'h001FFF);
            5: program_window(FERN_X0, FERN_Y0, FERN_SCALE, FERN_SCALE, 24'd1, 24'd1);
            NUM_PHASES - 1:
               program_window(FERN_X0, FERN_Y0, FERN_SCALE, FERN_SCALE, 24'd132, 24'd256);
            default: begin
               if ($urandom_range(0, 2) == 0)
                  program_window(CSR_W'($urandom()), CSR_W'($urandom()),
                                 CSR_W'($urandom()), CSR_W'($urandom()),
                                 CSR_W'($urandom()), CSR_W'($urandom()));
               else
                  program_window(CSR_W'(FERN_X0 - $urandom_range(0, 65536)),
                                 CSR_W'(FERN_Y0 + $urandom_range(0, 65536)),
                                 CSR_W'($urandom_range(4096, 1228800)),
                                 CSR_W'($urandom_range(4096, 1228800)),
                                 CSR_W'($urandom_range(1, 4096)),
                                 CSR_W'($urandom_range(1, 4096)));
            end
         endcase
         if (p == NUM_PHASES - 1 || p % 4 == 3) idle_odds = 0;
         else idle_odds = $urandom_range(2, 12);
         repeat (PHASE_ITEMS) fraction_queue.push_back(draw_fraction());
         // receiver backs off while requests keep coming
         if (p == 7) long_hold_request = 1'b1;
      end

      wait_idle();
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
